// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the LED chain driver RTL.
// Used inside modules that have clk_i and rst_ni ports; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ASSERT_CLK(name, prop, msg)
`define ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ===== rtl/rgbled_pkg.sv =====
// Shared types, codes and constants of the LED chain driver.
// No dependencies; imported by every module of the block but rgbled_ram.
package rgbled_pkg;

  // Pixel store geometry.
  localparam int PIXEL_DEPTH    = 256;
  localparam int PIX_AW         = $clog2(PIXEL_DEPTH);
  localparam int PIX_CW         = $clog2(PIXEL_DEPTH + 1);
  localparam int PIX_W          = 24;
  localparam int BITS_PER_PIXEL = 24;

  // Command codes carried in the input tuser.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SHOW  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ONE_HIGH  = 3'd0;
  localparam logic [2:0] CFG_ONE_LOW   = 3'd1;
  localparam logic [2:0] CFG_ZERO_HIGH = 3'd2;
  localparam logic [2:0] CFG_ZERO_LOW  = 3'd3;
  localparam logic [2:0] CFG_LATCH     = 3'd4;
  localparam logic [2:0] CFG_PIXELS    = 3'd5;

  // Phase of the serial data line.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // input word taken this cycle
    logic exec;    // execute the held item and load the result
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic ignored;
    logic frame_done;
    logic busy_res;
    logic line_level;
  } result_t;

  // A tick count of zero behaves as one.
  function automatic logic [11:0] at_least_one(input logic [11:0] v);
    return (v == 12'd0) ? 12'd1 : v;
  endfunction

endpackage

// ===== rtl/rgbled_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rgbled_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rgbled_ctrl.sv =====
// Controller of the LED chain driver: item sequencing and stream handshakes.
// Depends on rgbled_pkg.
module rgbled_ctrl
  import rgbled_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;
  logic   exec;

  // An item is taken in the idle state; it executes once the output slot is free.
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign exec       = (state_q == S_EXEC) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // The output word stays valid until the receiver takes it.
  always_comb begin
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cmd_o.accept = accept;
  assign cmd_o.exec   = exec;

endmodule

// ===== rtl/rgbled_dp.sv =====
// Datapath of the LED chain driver: pixel store, configuration registers,
// serialiser state and the result register. Depends on rgbled_pkg, rgbled_ram and assert_macros.svh.
`include "assert_macros.svh"
module rgbled_dp
  import rgbled_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [1:0]  in_op_i,
  input  logic [31:0] in_data_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  output result_t     result_o
);

  // Configuration registers.
  logic [7:0]  one_high_q, one_low_q, zero_high_q, zero_low_q;
  logic [11:0] latch_q;
  logic [8:0]  pixels_q;

  // Held input item.
  logic [1:0]  op_q;
  logic [7:0]  idx_q, red_q, green_q, blue_q;

  // Serialiser state.
  phase_e              phase_q, phase_d;
  logic [11:0]         ticks_q, ticks_d;
  logic [PIX_CW-1:0]   pix_cnt_q, pix_cnt_d;
  logic [4:0]          bit_cnt_q, bit_cnt_d;
  logic [PIX_W-1:0]    shift_q, shift_d;

  // Pixel store and its written-entry flags.
  logic [PIXEL_DEPTH-1:0] wr_flag_q;
  logic                   rd_flag_q;
  logic [PIX_AW-1:0]      rd_addr;
  logic [PIX_W-1:0]       ram_rdata;
  logic [PIX_W-1:0]       mem_pix;
  logic                   ram_we;

  result_t result_q, result_d;

  logic              busy;
  logic              done;
  logic              dropped;
  logic              idx_ok;
  logic [11:0]       ticks_dec;
  logic [PIX_W-1:0]  shifted;
  logic [4:0]        bit_inc;
  logic [PIX_CW-1:0] pix_inc;
  logic [8:0]        pix_req;
  logic [PIX_CW-1:0] frame_len;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_high_q  <= 8'd13;
      one_low_q   <= 8'd7;
      zero_high_q <= 8'd6;
      zero_low_q  <= 8'd14;
      latch_q     <= 12'd800;
      pixels_q    <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ONE_HIGH:  one_high_q  <= cfg_data_i[7:0];
        CFG_ONE_LOW:   one_low_q   <= cfg_data_i[7:0];
        CFG_ZERO_HIGH: zero_high_q <= cfg_data_i[7:0];
        CFG_ZERO_LOW:  zero_low_q  <= cfg_data_i[7:0];
        CFG_LATCH:     latch_q     <= cfg_data_i;
        CFG_PIXELS:    pixels_q    <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Capture the item word when it is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= in_op_i;
      idx_q   <= in_data_i[7:0];
      red_q   <= in_data_i[15:8];
      green_q <= in_data_i[23:16];
      blue_q  <= in_data_i[31:24];
    end
  end

  // A show needs pixel 0; a tick may need the next pixel of the frame.
  assign pix_inc = pix_cnt_q + 1'b1;
  assign rd_addr = (in_op_i == OP_SHOW) ? '0 : pix_inc[PIX_AW-1:0];

  assign idx_ok  = 32'(idx_q) < 32'(PIXEL_DEPTH);
  assign ram_we  = cmd_i.exec && (op_q == OP_WRITE) && !busy && idx_ok;

  rgbled_ram #(
    .WIDTH(PIX_W),
    .DEPTH(PIXEL_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q[PIX_AW-1:0]),
    .wdata_i({green_q, red_q, blue_q}),
    .re_i   (cmd_i.accept),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // Entries never written since reset read as black.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_flag_q <= '0;
      rd_flag_q <= 1'b0;
    end else begin
      if (ram_we) begin
        wr_flag_q[idx_q[PIX_AW-1:0]] <= 1'b1;
      end
      if (cmd_i.accept) begin
        rd_flag_q <= wr_flag_q[rd_addr];
      end
    end
  end

  assign mem_pix = rd_flag_q ? ram_rdata : '0;

  // Frame length: a count of zero sends one pixel, and it is capped at the store depth.
  assign pix_req   = (pixels_q == 9'd0) ? 9'd1 : pixels_q;
  assign frame_len = (32'(pix_req) > 32'(PIXEL_DEPTH)) ? PIX_CW'(PIXEL_DEPTH)
                                                        : PIX_CW'(pix_req);

  assign busy      = (phase_q != PH_IDLE);
  assign ticks_dec = (ticks_q != 12'd0) ? ticks_q - 12'd1 : ticks_q;
  assign shifted   = {shift_q[PIX_W-2:0], 1'b0};
  assign bit_inc   = bit_cnt_q + 5'd1;

  // Next serialiser state for the held item.
  always_comb begin
    phase_d   = phase_q;
    ticks_d   = ticks_q;
    pix_cnt_d = pix_cnt_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    done      = 1'b0;
    dropped   = 1'b0;
    case (op_q)
      OP_WRITE: begin
        dropped = busy;
      end
      OP_SHOW: begin
        if (busy) begin
          dropped = 1'b1;
        end else begin
          pix_cnt_d = '0;
          bit_cnt_d = 5'd0;
          shift_d   = mem_pix;
          phase_d   = PH_HIGH;
          ticks_d   = at_least_one({4'd0, mem_pix[PIX_W-1] ? one_high_q : zero_high_q});
        end
      end
      OP_TICK: begin
        if (busy) begin
          ticks_d = ticks_dec;
          if (ticks_dec == 12'd0) begin
            case (phase_q)
              PH_HIGH: begin
                phase_d = PH_LOW;
                ticks_d = at_least_one({4'd0, shift_q[PIX_W-1] ? one_low_q : zero_low_q});
              end
              PH_LOW: begin
                shift_d   = shifted;
                bit_cnt_d = bit_inc;
                if (bit_inc < 5'(BITS_PER_PIXEL)) begin
                  phase_d = PH_HIGH;
                  ticks_d = at_least_one({4'd0,
                                          shifted[PIX_W-1] ? one_high_q : zero_high_q});
                end else if (pix_inc < frame_len) begin
                  pix_cnt_d = pix_inc;
                  bit_cnt_d = 5'd0;
                  shift_d   = mem_pix;
                  phase_d   = PH_HIGH;
                  ticks_d   = at_least_one({4'd0,
                                            mem_pix[PIX_W-1] ? one_high_q : zero_high_q});
                end else begin
                  phase_d = PH_LATCH;
                  ticks_d = at_least_one(latch_q);
                end
              end
              default: begin
                // End of the latch period: back to idle.
                phase_d   = PH_IDLE;
                pix_cnt_d = '0;
                bit_cnt_d = 5'd0;
                shift_d   = '0;
                done      = 1'b1;
              end
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  // Result word as seen after the item.
  always_comb begin
    result_d.line_level = (phase_d == PH_HIGH);
    result_d.busy_res   = (phase_d != PH_IDLE);
    result_d.frame_done = done;
    result_d.ignored    = dropped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      ticks_q   <= 12'd0;
      pix_cnt_q <= '0;
      bit_cnt_q <= 5'd0;
      shift_q   <= '0;
      result_q  <= '0;
    end else if (cmd_i.exec) begin
      phase_q   <= phase_d;
      ticks_q   <= ticks_d;
      pix_cnt_q <= pix_cnt_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
      result_q  <= result_d;
    end
  end

  assign result_o = result_q;

  // Consistency of the serialiser state and the result word.
  // The bit counter rests at the full pixel width during the latch period.
  `ASSERT_CLK(a_ticks_loaded, (phase_q != PH_IDLE) |-> (ticks_q != 12'd0), "phase without ticks")
  `ASSERT_CLK(a_bit_range, bit_cnt_q <= 5'(BITS_PER_PIXEL), "bit counter out of range")
  `ASSERT_CLK(a_high_busy, result_q.line_level |-> result_q.busy_res, "line high while not busy")
  `ASSERT_CLK(a_done_idle, result_q.frame_done |-> (!result_q.busy_res && phase_q == PH_IDLE),
              "frame done while busy")

endmodule

// ===== rtl/rgb_led_chain_driver_top.sv =====
// Top level of the single-wire RGB LED chain driver.
// Depends on rgbled_pkg, rgbled_ctrl, rgbled_dp and rgbled_ram.
//
// Input stream: tuser carries the command (write pixel, show frame, one tick);
// tdata carries pixel index and colour for a write. Every input word produces
// exactly one output word holding the data line level after the item, the busy
// flag, a frame-done flag and an ignored flag for writes or shows dropped while
// a frame is in progress. Configuration writes use a separate valid/ready
// channel that is always ready and must only be used while the block is idle.
// A word is accepted into the held-item registers and executes once the output
// register is free, loading its result word there. No new word is taken until
// the previous one has executed; the store is read, registered, before each executes.
// Reset restores the default timing registers, returns the line to idle and
// marks every pixel unwritten, so the whole store reads as black at once.
// When the receiver stalls the result word is held; one further input word is
// still accepted and then waits until the output register is free.
module rgb_led_chain_driver_top
  import rgbled_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // pixel_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // line_level[0], busy_res[1], frame_done[2], ignored[3]
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  cmd_t    cmd;
  result_t result;

  assign cfg_ready_o = 1'b1;

  rgbled_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd)
  );

  rgbled_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_op_i    (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (result)
  );

  // Pack the result word, first field in the lowest bit.
  assign m_axis_tdata = {4'd0, result.ignored, result.frame_done,
                         result.busy_res, result.line_level};

endmodule

// ===== bench/rgb_led_chain_driver_top_test.sv =====
// Self-checking bench for the single-wire RGB LED chain driver top level.
// Needs rgbled_pkg and rgb_led_chain_driver_top; predicts every result word
// from its own model of the pixel store and the line waveform.
`timescale 1ns / 100ps

module rgb_led_chain_driver_top_test;
  import rgbled_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int PHASE_ITEMS     = 100;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 4000;

  // One command word as queued for the sender.
  typedef struct {
    logic [1:0] op;
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } led_cmd_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // pixel_index[7:0], red[15:8], green[23:16], blue[31:24]
  logic [1:0]  s_axis_tuser  = '0;  // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // line_level[0], busy_res[1], frame_done[2], ignored[3]
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i   = '0;
  logic [11:0] cfg_data_i    = '0;

  // Bench bookkeeping.
  led_cmd_t led_cmd_q[$];
  result_t  line_word_q[$];
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  logic hold_off_req = 1'b0;
  int hold_off_left;
  int quiet_cycles;
  int fail_cnt      = 0;
  int words_sent    = 0;
  int words_checked = 0;
  int frames_seen   = 0;
  int drops_seen    = 0;

  // Predicted timing registers.
  logic [7:0]  one_hi_t, one_lo_t, zero_hi_t, zero_lo_t;
  logic [11:0] latch_t;
  logic [8:0]  npix_t;

  // Predicted store and line state.
  logic [23:0] led_store [PIXEL_DEPTH];
  int          pix_cnt;
  int          bit_cnt;
  logic [23:0] shift;
  logic [11:0] ph_ticks;
  phase_e      line_ph;

  rgb_led_chain_driver_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A pulse or latch length of zero lasts one tick.
  function automatic logic [11:0] nonzero(input logic [11:0] v);
    return (v == '0) ? 12'd1 : v;
  endfunction

  // Pixels sent per frame, with zero read as one and capped at the store depth.
  function automatic int frame_len();
    int n;
    n = (npix_t == '0) ? 1 : int'(npix_t);
    return (n > PIXEL_DEPTH) ? PIXEL_DEPTH : n;
  endfunction

  function automatic void drive_bit_high();
    line_ph  = PH_HIGH;
    ph_ticks = nonzero({4'd0, shift[23] ? one_hi_t : zero_hi_t});
  endfunction

  function automatic void load_pixel(input int i);
    pix_cnt = i;
    bit_cnt = 0;
    shift   = led_store[i];
    drive_bit_high();
  endfunction

  // Applies one command word to the predicted state and gives its result word.
  function automatic result_t led_line_step(input logic [1:0] op, input logic [7:0] idx,
                                            input logic [7:0] red, green, blue);
    result_t res;
    logic    busy;
    res  = '0;
    busy = (line_ph != PH_IDLE);
    case (op)
      OP_WRITE: begin
        if (busy) res.ignored = 1'b1;
        else led_store[idx] = {green, red, blue};
      end
      OP_SHOW: begin
        if (busy) res.ignored = 1'b1;
        else load_pixel(0);
      end
      OP_TICK: begin
        if (busy) begin
          if (ph_ticks != '0) ph_ticks = ph_ticks - 12'd1;
          if (ph_ticks == '0) begin
            case (line_ph)
              PH_HIGH: begin
                line_ph  = PH_LOW;
                ph_ticks = nonzero({4'd0, shift[23] ? one_lo_t : zero_lo_t});
              end
              PH_LOW: begin
                shift   = shift << 1;
                bit_cnt = bit_cnt + 1;
                if (bit_cnt < BITS_PER_PIXEL) begin
                  drive_bit_high();
                end else if (pix_cnt + 1 < frame_len()) begin
                  load_pixel(pix_cnt + 1);
                end else begin
                  line_ph  = PH_LATCH;
                  ph_ticks = nonzero(latch_t);
                end
              end
              default: begin
                line_ph         = PH_IDLE;
                pix_cnt         = 0;
                bit_cnt         = 0;
                shift           = '0;
                res.frame_done  = 1'b1;
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    res.line_level = (line_ph == PH_HIGH);
    res.busy_res   = (line_ph != PH_IDLE);
    return res;
  endfunction

  // Sender: offers queued command words, holding each one until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin : tx_drive
    led_cmd_t cmd;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        line_word_q.push_back(led_line_step(s_axis_tuser, s_axis_tdata[7:0],
                                            s_axis_tdata[15:8], s_axis_tdata[23:16],
                                            s_axis_tdata[31:24]));
        words_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (led_cmd_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          cmd = led_cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cmd.op;
          s_axis_tdata  <= {cmd.blue, cmd.green, cmd.red, cmd.idx};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off_left <= 0;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_req) begin
      hold_off_left <= HOLD_OFF_CYCLES;
    end
  end

  // Receiver: compares each result word with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : rx_check
    result_t got;
    result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[3:0]);
        if (line_word_q.size() == 0) begin
          $error("result word 0x%02h arrived with no prediction waiting", m_axis_tdata);
          fail_cnt++;
        end else begin
          want = line_word_q.pop_front();
          words_checked++;
          if (want.frame_done) frames_seen++;
          if (want.ignored) drops_seen++;
          if (got.line_level !== want.line_level) begin
            $error("line_level: expected %0b, got %0b", want.line_level, got.line_level);
            fail_cnt++;
          end
          if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
            fail_cnt++;
          end
          if (got.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0b, got %0b", want.frame_done, got.frame_done);
            fail_cnt++;
          end
          if (got.ignored !== want.ignored) begin
            $error("ignored: expected %0b, got %0b", want.ignored, got.ignored);
            fail_cnt++;
          end
        end
      end
      m_axis_tready <= (hold_off_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog on cycles in which no word moves on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_cmd(input logic [1:0] op, input logic [7:0] idx,
                          input logic [7:0] red, green, blue);
    led_cmd_t cmd;
    cmd.op    = op;
    cmd.idx   = idx;
    cmd.red   = red;
    cmd.green = green;
    cmd.blue  = blue;
    led_cmd_q.push_back(cmd);
  endtask

  task automatic push_ticks(input int n);
    for (int k = 0; k < n; k++)
      push_cmd(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Sender pause: nothing queued, nothing offered, nothing outstanding.
  task automatic wait_empty();
    do @(negedge clk_i);
    while (led_cmd_q.size() != 0 || s_axis_tvalid || line_word_q.size() != 0);
  endtask

  // Ticks the line until any frame in flight has latched, then lets it settle.
  task automatic finish_frame();
    wait_empty();
    while (line_ph != PH_IDLE) begin
      push_ticks(16);
      wait_empty();
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Must be entered on a rising edge; returns on the edge the word is taken.
  task automatic cfg_write(input logic [2:0] idx, input int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[11:0];
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      CFG_ONE_HIGH:  one_hi_t  = val[7:0];
      CFG_ONE_LOW:   one_lo_t  = val[7:0];
      CFG_ZERO_HIGH: zero_hi_t = val[7:0];
      CFG_ZERO_LOW:  zero_lo_t = val[7:0];
      CFG_LATCH:     latch_t   = val[11:0];
      CFG_PIXELS:    npix_t    = val[8:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(input int oh, ol, zh, zl, lt, np);
    @(posedge clk_i);
    cfg_write(CFG_ONE_HIGH, oh);
    cfg_write(CFG_ONE_LOW, ol);
    cfg_write(CFG_ZERO_HIGH, zh);
    cfg_write(CFG_ZERO_LOW, zl);
    cfg_write(CFG_LATCH, lt);
    cfg_write(CFG_PIXELS, np);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed frames (some writes, a show, a run of ticks) with noise
  // sprinkled in; a show landing in a running frame is dropped by the block.
  task automatic push_random(input int n);
    int cnt;
    int nw;
    int nt;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(99) < 80) begin
        nw = $urandom_range(3);
        for (int k = 0; k < nw; k++)
          push_cmd(OP_WRITE,
                   ($urandom_range(3) != 0) ? 8'($urandom_range(frame_len() - 1))
                                            : 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
        push_cmd(OP_SHOW, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        nt = $urandom_range(8, 120);
        for (int k = 0; k < nt; k++) begin
          if ($urandom_range(99) < 6)
            push_cmd(2'($urandom_range(3)), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
          else
            push_ticks(1);
        end
        cnt += nw + 1 + nt;
      end else begin
        nt = $urandom_range(1, 6);
        for (int k = 0; k < nt; k++)
          push_cmd(2'($urandom_range(3)), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom));
        cnt += nt;
      end
    end
  endtask

  initial begin
    // Predicted state after reset.
    one_hi_t  = 8'd13;
    one_lo_t  = 8'd7;
    zero_hi_t = 8'd6;
    zero_lo_t = 8'd14;
    latch_t   = 12'd800;
    npix_t    = 9'd256;
    foreach (led_store[i]) led_store[i] = '0;
    pix_cnt  = 0;
    bit_cnt  = 0;
    shift    = '0;
    ph_ticks = '0;
    line_ph  = PH_IDLE;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Idle behaviour at the reset timing: ticks and no-ops, store writes.
    push_cmd(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(OP_NOP, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(OP_WRITE, 8'd0, 8'hFF, 8'h00, 8'hAA);
    push_cmd(OP_WRITE, 8'd255, 8'h00, 8'hFF, 8'h55);
    push_cmd(OP_WRITE, 8'd1, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(OP_WRITE, 8'd2, 8'h00, 8'h00, 8'h00);
    push_cmd(OP_WRITE, 8'd128, 8'h5A, 8'hA5, 8'h0F);
    push_cmd(OP_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    finish_frame();

    // Short two-pixel frame with zero-length pulses and latch; the write and show
    // sent while it runs must be dropped.
    set_timing(1, 0, 0, 2, 0, 2);
    push_cmd(OP_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(OP_WRITE, 8'd3, 8'h12, 8'h34, 8'h56);
    push_cmd(OP_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(OP_NOP, 8'h00, 8'h00, 8'h00, 8'h00);
    push_ticks(3);
    finish_frame();

    // Random phases: each a timing setting paired with a handshake idling mode.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 56; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 56; end
        default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
      endcase
      finish_frame();
      case (ph)
        0: set_timing(1, 1, 1, 1, 1, 1);
        1: set_timing(0, 0, 0, 0, 0, 0);
        2: set_timing(3, 2, 1, 4, 5, 3);
        4: set_timing(9, 4, 3, 10, 260, 1);
        5: set_timing(1, 1, 1, 1, 1, 4);
        6: set_timing(1, 2, 2, 1, 3, 5);
        default: set_timing($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
                            $urandom_range(1, 6), $urandom_range(20), $urandom_range(1, 4));
      endcase
      push_random(PHASE_ITEMS / 2);
      if (ph == 2) begin
        // Receiver holds off while the sender keeps offering words.
        @(negedge clk_i) hold_off_req = 1'b1;
        @(negedge clk_i) hold_off_req = 1'b0;
      end
      if (ph == 7) wait_empty();
      push_random(PHASE_ITEMS - PHASE_ITEMS / 2);
    end
    finish_frame();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d command words (%0d dropped while busy), checked %0d result words,",
             words_sent, drops_seen, words_checked);
    $display("%0d frames latched over nine timing settings and four idling modes.",
             frames_seen);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
